@@ hdl/swm_pkg.sv @@
// Shared types, sizes and helper function for the sliding window minimum block.
`default_nettype none
package swm_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int CFG_W        = 7;
    localparam int LEN_W        = ($clog2(MAX_WINDOW + 1) > CFG_W) ?
                                  $clog2(MAX_WINDOW + 1) : CFG_W;
    localparam int AGE_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(3);

    typedef logic [LEN_W-1:0] len_t;
    typedef logic [AGE_W-1:0] age_t;
    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // One entry of the ascending-minimum queue.
    typedef struct packed {
        logic    valid;
        age_t    age;
        sample_t value;
    } cell_t;

    // Signals broadcast from the control to every cell.
    typedef struct packed {
        logic    accept;
        logic    clear;
        logic    shift;
        sample_t sample;
        len_t    len;
    } bcast_t;

    // Per-cell status seen by the control.
    typedef struct packed {
        logic keep;
        logic expired;
    } cell_stat_t;

    // Zero counts as one; values above the cell count saturate.
    function automatic len_t eff_len(input logic [CFG_W-1:0] v);
        len_t ext;
        ext = LEN_W'(v);
        if (ext == '0) begin
            ext = LEN_W'(1);
        end else if (ext > LEN_W'(MAX_WINDOW)) begin
            ext = LEN_W'(MAX_WINDOW);
        end
        return ext;
    endfunction

endpackage
`default_nettype wire

@@ hdl/sliding_window_minimum.sv @@
// Top level of the sliding window minimum block: control, cell row and output register.
//
// Usage: samples arrive on the s_ stream channel, one per transfer, and each
// accepted sample yields one result on the m_ stream channel: the minimum of the
// most recent window_length samples (fewer while the window fills) in m_tdata,
// and in m_tuser a flag that is high once the window holds window_length samples.
// The window is held as an ascending-minimum queue in a row of MAX_WINDOW cells;
// every cell compares its entry with the new sample in parallel, and the row
// shifts one place toward the head when the oldest entry ages out.
// The result is registered and shows in the cycle after the input transfer.
// Throughput: one sample per cycle while the receiver keeps up; the input stays
// ready while the output register is empty or being drained.
// When the receiver stalls, the result waits in the output register and s_tready
// drops until it is taken.
// The user must write the window length through the cfg_ channel only while idle;
// the block does not enforce it. A write clears the held samples; zero acts as one
// and values above MAX_WINDOW saturate. Reset (aresetn low, synchronous) empties
// the window, drops m_tvalid and sets the length to 3; no clearing pass is needed.
`default_nettype none
module sliding_window_minimum (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [swm_pkg::TDATA_W-1:0] s_tdata,   // [31:0] sample
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [swm_pkg::TDATA_W-1:0]      m_tdata,   // [31:0] window_min
    output logic [0:0]                       m_tuser,   // [0] window_full
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [swm_pkg::CFG_W-1:0]   cfg_data   // [6:0] window_length
);

    localparam int N = swm_pkg::MAX_WINDOW;

    swm_pkg::len_t       len_reg;
    swm_pkg::len_t       fill_reg;
    swm_pkg::len_t       fill_next;
    logic                m_valid_reg;
    swm_pkg::sample_t    min_reg;
    swm_pkg::sample_t    min_next;
    logic                full_reg;
    logic                full_next;

    logic                s_xfer;
    logic                cfg_xfer;
    swm_pkg::sample_t    sample;
    swm_pkg::bcast_t     bcast;

    swm_pkg::cell_t      cells     [N];
    swm_pkg::cell_stat_t stats     [N];
    logic [N-1:0]        src_kept;
    logic [N-1:0]        prev_kept;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign sample    = s_tdata[swm_pkg::SAMPLE_WIDTH-1:0];

    always_comb begin
        bcast.accept = s_xfer;
        bcast.clear  = cfg_xfer;
        bcast.shift  = stats[0].expired;
        bcast.sample = sample;
        bcast.len    = len_reg;
    end

    // Surviving entries form a prefix; after a shift each cell looks one place on.
    for (genvar i = 0; i < N; i++) begin : g_cell
        swm_pkg::cell_t right_state;
        logic           right_keep;

        if (i == N - 1) begin : g_last
            assign right_state = '0;
            assign right_keep  = 1'b0;
        end else begin : g_mid
            assign right_state = cells[i+1];
            assign right_keep  = stats[i+1].keep;
        end

        if (i == 0) begin : g_head
            assign prev_kept[i] = 1'b1;
        end else begin : g_tail
            assign prev_kept[i] = bcast.shift ? stats[i].keep : stats[i-1].keep;
        end

        assign src_kept[i] = bcast.shift ? right_keep : stats[i].keep;

        swm_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .bcast       (bcast),
            .right_state (right_state),
            .src_kept    (src_kept[i]),
            .prev_kept   (prev_kept[i]),
            .state       (cells[i]),
            .stat        (stats[i])
        );
    end

    // The new head of the queue is the window minimum.
    always_comb begin
        if (src_kept[0]) begin
            min_next = bcast.shift ? cells[(N > 1) ? 1 : 0].value : cells[0].value;
        end else begin
            min_next = sample;
        end
        fill_next = (fill_reg < len_reg) ? fill_reg + swm_pkg::LEN_W'(1) : len_reg;
        full_next = (fill_next == len_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= swm_pkg::eff_len(swm_pkg::LEN_RESET);
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_xfer) begin
                len_reg  <= swm_pkg::eff_len(cfg_data);
                fill_reg <= '0;
            end else if (s_xfer) begin
                fill_reg <= fill_next;
            end
            if (s_xfer) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_xfer) begin
            min_reg  <= min_next;
            full_reg <= full_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = swm_pkg::TDATA_W'($unsigned(min_reg));
    assign m_tuser  = full_reg;

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_tvalid)
        else $error("result missing after input transfer");

    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && !cfg_xfer) |=> cells[0].valid)
        else $error("queue head empty after a sample");

    a_min_is_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && !cfg_xfer) |=> (min_reg == cells[0].value))
        else $error("result does not match queue head");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= len_reg)
        else $error("fill count above window length");

endmodule
`default_nettype wire

@@ hdl/swm_cell.sv @@
// One cell of the ascending-minimum queue: holds a sample and its age.
`default_nettype none
module swm_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire swm_pkg::bcast_t    bcast,
    input  wire swm_pkg::cell_t     right_state,
    input  wire logic               src_kept,
    input  wire logic               prev_kept,
    output swm_pkg::cell_t          state,
    output swm_pkg::cell_stat_t     stat
);

    swm_pkg::cell_t cell_reg;
    swm_pkg::cell_t cell_next;
    swm_pkg::cell_t src;

    // An entry leaves once the new sample pushes it out of the window.
    always_comb begin
        stat.expired = cell_reg.valid &&
            ((swm_pkg::LEN_W'(cell_reg.age) + swm_pkg::LEN_W'(1)) >= bcast.len);
        stat.keep    = cell_reg.valid && !stat.expired &&
            (cell_reg.value < bcast.sample);
    end

    always_comb begin
        src       = bcast.shift ? right_state : cell_reg;
        cell_next = cell_reg;
        if (bcast.clear) begin
            cell_next.valid = 1'b0;
        end else if (bcast.accept) begin
            if (src_kept) begin
                cell_next.valid = 1'b1;
                cell_next.value = src.value;
                cell_next.age   = src.age + swm_pkg::AGE_W'(1);
            end else if (prev_kept) begin
                // First slot past the surviving entries takes the new sample.
                cell_next.valid = 1'b1;
                cell_next.value = bcast.sample;
                cell_next.age   = '0;
            end else begin
                cell_next.valid = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else begin
            cell_reg.valid <= cell_next.valid;
        end
        cell_reg.age   <= cell_next.age;
        cell_reg.value <= cell_next.value;
    end

    assign state = cell_reg;

endmodule
`default_nettype wire
